>>> sv/lps_pkg.sv
// Shared sizes, status codes and helpers for the linear prime sieve.
package lps_pkg;

  localparam int MAX_N      = 16384;
  localparam int MAX_PRIMES = 2048;

  localparam int N_W     = 14;
  localparam int PROD_W  = 2 * N_W;
  localparam int ADDR_W  = $clog2(MAX_N);
  localparam int LIST_AW = $clog2(MAX_PRIMES);
  localparam int CNT_W   = $clog2(MAX_PRIMES + 1);

  localparam logic [N_W-1:0] LIMIT_RST  = N_W'(16383);
  localparam logic [N_W-1:0] FIRST_N    = N_W'(2);
  localparam logic [N_W-1:0] TABLE_TOP  =
    N_W'(((MAX_N - 1) < ((1 << N_W) - 1)) ? (MAX_N - 1) : ((1 << N_W) - 1));

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_LIMIT = 2'd2
  } lps_status_t;

  // Clamp the programmed limit to the last table entry.
  function automatic logic [N_W-1:0] eff_limit(input logic [N_W-1:0] lim);
    return (lim > TABLE_TOP) ? TABLE_TOP : lim;
  endfunction

endpackage

>>> sv/lps_check.sv
// Classifies an incoming number as in order, out of order or above the limit.
module lps_check (
  input  logic [lps_pkg::N_W-1:0] number,
  input  logic [lps_pkg::N_W-1:0] expected,
  input  logic [lps_pkg::N_W-1:0] limit,
  output lps_pkg::lps_status_t    status
);
  import lps_pkg::*;

  always_comb begin
    if ((number < FIRST_N) || (number != expected)) begin
      status = ST_ORDER;
    end else if (number > eff_limit(limit)) begin
      status = ST_LIMIT;
    end else begin
      status = ST_OK;
    end
  end

endmodule

>>> sv/linear_prime_sieve.sv
// Linear (Euler) prime sieve top level: factor table, prime list and walk sequencer.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   input   | in_valid, in_ready, number                     | in
//   result  | out_valid, out_ready, echo_number, is_prime,   | out
//           | least_factor, status                           |
//   config  | cfg_we, cfg_data (limit)                       | in
//
// After reset the factor table is cleared one entry per cycle (all MAX_N
// entries, 16384 with the package sizes); no number is taken until that pass ends.
// An in-order number passes the lookup and walk read states, then a multiply
// and a write state per listed prime walked; each walk step is a prime list
// read, a multiply and a factor table write. A rejected number goes from idle
// straight to done. The result register holds a finished result while the
// output side stalls; the sequencer waits in its done state until it drains.
module linear_prime_sieve (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [lps_pkg::N_W-1:0] number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [lps_pkg::N_W-1:0] echo_number,
  output logic                    is_prime,
  output logic [lps_pkg::N_W-1:0] least_factor,
  output logic [1:0]              status,
  input  logic                    cfg_we,
  input  logic [lps_pkg::N_W-1:0] cfg_data
);
  import lps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_LOOKUP   = 6'b000010,
    S_WALK_RD  = 6'b000100,
    S_WALK_MUL = 6'b001000,
    S_WALK_WR  = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t state;

  // Memories: least factor per number, and primes in the order found.
  logic [N_W-1:0] factor_table [MAX_N];
  logic [N_W-1:0] prime_list   [MAX_PRIMES];

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [N_W-1:0]    limit_r;
  logic [N_W-1:0]    expected;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  j_inc;

  // Per-item working registers.
  logic [N_W-1:0]    cur_n;
  logic [N_W-1:0]    lf;
  logic              prime_r;
  lps_status_t       res_status;
  logic [N_W-1:0]    p_r;
  logic [PROD_W-1:0] prod;
  logic              prod_over;

  logic [N_W-1:0]     tbl_rdata;
  logic [N_W-1:0]     list_rdata;
  logic               tbl_we;
  logic [ADDR_W-1:0]  tbl_waddr;
  logic [N_W-1:0]     tbl_wdata;
  logic [LIST_AW-1:0] list_raddr;
  logic               list_we;
  logic               acc;
  logic               res_load;
  lps_status_t        chk_status;

  lps_check u_check (
    .number   (number),
    .expected (expected),
    .limit    (limit_r),
    .status   (chk_status)
  );

  assign in_ready  = (state == S_IDLE) && !clearing;
  assign acc       = in_valid && in_ready;
  assign j_inc     = j + 1'b1;
  assign prod_over = prod > PROD_W'(eff_limit(limit_r));
  // Load the result register once the previous result has left or is leaving.
  assign res_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Walk step issues the next list read early, in the write state, so the loop alternates multiply and write.
  assign list_raddr = (state == S_WALK_WR) ? j_inc[LIST_AW-1:0] : j[LIST_AW-1:0];
  assign list_we    = (state == S_LOOKUP) && (tbl_rdata == '0) &&
                      (count < CNT_W'(MAX_PRIMES));

  // One write port on the factor table: clearing pass, prime self-mark, or
  // marking a product during the walk.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_addr;
    tbl_wdata = '0;
    if (clearing) begin
      tbl_we = 1'b1;
    end else if ((state == S_LOOKUP) && (tbl_rdata == '0)) begin
      tbl_we    = 1'b1;
      tbl_waddr = ADDR_W'(cur_n);
      tbl_wdata = cur_n;
    end else if ((state == S_WALK_WR) && !prod_over) begin
      tbl_we    = 1'b1;
      tbl_waddr = ADDR_W'(prod);
      tbl_wdata = p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      factor_table[tbl_waddr] <= tbl_wdata;
    end
    // Read at the transfer; data is used in the lookup cycle right after.
    tbl_rdata <= factor_table[ADDR_W'(number)];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      prime_list[count[LIST_AW-1:0]] <= cur_n;
    end
    list_rdata <= prime_list[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      limit_r   <= LIMIT_RST;
      expected  <= FIRST_N;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(MAX_N - 1)) begin
          clearing <= 1'b0;
        end
      end
      // Hold valid until the transfer; a new result may replace a leaving one.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cur_n      <= number;
            res_status <= chk_status;
            prime_r    <= 1'b0;
            lf         <= '0;
            if (chk_status == ST_OK) begin
              expected <= number + 1'b1;
              state    <= S_LOOKUP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_LOOKUP: begin
          // Zero entry: prime; record it as its own factor and append it while the list has room.
          if (tbl_rdata == '0) begin
            prime_r <= 1'b1;
            lf      <= cur_n;
            if (count < CNT_W'(MAX_PRIMES)) begin
              count <= count + 1'b1;
            end
          end else begin
            lf <= tbl_rdata;
          end
          j     <= '0;
          state <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (j >= count) begin
            state <= S_DONE;
          end else begin
            state <= S_WALK_MUL;
          end
        end
        S_WALK_MUL: begin
          p_r   <= list_rdata;
          prod  <= PROD_W'(cur_n) * PROD_W'(list_rdata);
          state <= S_WALK_WR;
        end
        S_WALK_WR: begin
          // Stop past the limit, at the least factor, or at the list end.
          j <= j_inc;
          if (prod_over || (p_r == lf) || (j_inc >= count)) begin
            state <= S_DONE;
          end else begin
            state <= S_WALK_MUL;
          end
        end
        S_DONE: begin
          if (res_load) begin
            echo_number  <= cur_n;
            is_prime     <= prime_r;
            least_factor <= lf;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
